// ===== rtl/core/ossc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ossc_pkg
// Types, constants and the arctangent table of the obstacle sector check.
// ----------------------------------------------------------------------------
package ossc_pkg;

	localparam int POS_W     = 24;
	localparam int DELTA_W   = POS_W + 1;
	localparam int ANGLE_W   = 16;
	localparam int TIME_W    = 32;
	localparam int RANGE_W   = 23;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int SQ_W      = 2 * DELTA_W;
	localparam int GUARD_W   = 16;
	localparam int CORDIC_W  = 44;
	localparam int Z_W       = 32;
	localparam int TAB_LEN   = 24;
	localparam int SHIFT_W   = 5;

	localparam int ATAN_ITERATIONS_DEF = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_STOP_RANGE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_HALF_ANGLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_RANGE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_HALF_ANGLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_HOLD_MS    = 3'd4;

	localparam logic [RANGE_W-1:0] STOP_RANGE_RST      = 23'd3840;
	localparam logic [ANGLE_W-1:0] STOP_HALF_ANGLE_RST = 16'd182;
	localparam logic [RANGE_W-1:0] SLOW_RANGE_RST      = 23'd10240;
	localparam logic [ANGLE_W-1:0] SLOW_HALF_ANGLE_RST = 16'd3641;
	localparam logic [TIME_W-1:0]  STOP_HOLD_MS_RST    = 32'd5000;

	localparam logic [Z_W-1:0] Z_QUARTER       = 32'h4000_0000;
	localparam logic [Z_W-1:0] Z_THREE_QUARTER = 32'hC000_0000;
	localparam logic [Z_W-1:0] Z_ROUND         = 32'h0000_8000;

	localparam logic [Z_W-1:0] ATAN_TAB [TAB_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	typedef struct packed {
		logic                      action;
		logic signed [POS_W-1:0]   obs_x;
		logic signed [POS_W-1:0]   obs_y;
		logic signed [POS_W-1:0]   car_x;
		logic signed [POS_W-1:0]   car_y;
		logic [ANGLE_W-1:0]        car_heading;
		logic [TIME_W-1:0]         frame_time_ms;
		logic                      frame_last;
	} ossc_in_t;

	typedef struct packed {
		logic stop_active;
		logic slow_seen;
	} ossc_out_t;

	typedef struct packed {
		logic               load;
		logic               step;
		logic [SHIFT_W-1:0] shift;
	} ossc_cordic_ctl_t;

endpackage

// ===== rtl/core/ossc_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ossc_cordic
// Vectoring cordic: one micro-rotation per step, bearing rounded to 16 bits.
// ----------------------------------------------------------------------------
module ossc_cordic (
	input  logic                              clk,
	input  ossc_pkg::ossc_cordic_ctl_t        ctl,
	input  logic signed [ossc_pkg::DELTA_W-1:0] dx,
	input  logic signed [ossc_pkg::DELTA_W-1:0] dy,
	output logic [ossc_pkg::ANGLE_W-1:0]      bearing
);
	import ossc_pkg::*;

	logic signed [CORDIC_W-1:0] x_q, y_q;
	logic [Z_W-1:0]             z_q;
	logic                       zero_q;

	logic signed [CORDIC_W-1:0] xe, ye, xs, ys;
	logic [Z_W-1:0]             zr;

	assign xe = {{(CORDIC_W-DELTA_W-GUARD_W){dx[DELTA_W-1]}}, dx, {GUARD_W{1'b0}}};
	assign ye = {{(CORDIC_W-DELTA_W-GUARD_W){dy[DELTA_W-1]}}, dy, {GUARD_W{1'b0}}};
	assign xs = x_q >>> ctl.shift;
	assign ys = y_q >>> ctl.shift;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			zero_q <= (dx == '0) && (dy == '0);
			if (!dx[DELTA_W-1]) begin
				x_q <= xe;
				y_q <= ye;
				z_q <= '0;
			end else if (!dy[DELTA_W-1]) begin
				x_q <= ye;
				y_q <= -xe;
				z_q <= Z_QUARTER;
			end else begin
				x_q <= -ye;
				y_q <= xe;
				z_q <= Z_THREE_QUARTER;
			end
		end else if (ctl.step) begin
			if (!y_q[CORDIC_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ATAN_TAB[ctl.shift];
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ATAN_TAB[ctl.shift];
			end
		end
	end

	assign zr      = z_q + Z_ROUND;
	assign bearing = zero_q ? '0 : zr[Z_W-1 -: ANGLE_W];

endmodule

// ===== rtl/core/obstacle_sector_stop_slow_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obstacle_sector_stop_slow_check
// Per-point stop/slow sector test with frame flags and a timed stop latch.
// ----------------------------------------------------------------------------
//  channel   signals                         direction  meaning
//  obs       obs_valid/obs_ready/obs_item    in         one point or frame end
//  res       res_valid/res_ready/res_item    out        one result per frame end
//  cfg       cfg_we/cfg_index/cfg_data       in         register write, no wait
//
//  a point is accepted in ST_IDLE, then runs one cordic micro-rotation per
//  cycle in ST_CORDIC and one check in ST_CHECK; the squares
//  run on a shared 25x25 multiplier under the first cordic cycles
//  a frame end adds the ST_FRAME state, held while the result register is still full
//  items without a point, or after a stop point, skip the cordic
//  arst_n loads the config defaults and clears the flags, the latch and the result register
// ----------------------------------------------------------------------------
module obstacle_sector_stop_slow_check #(
	parameter int ATAN_ITERATIONS = ossc_pkg::ATAN_ITERATIONS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            obs_valid,
	output logic                            obs_ready,
	input  ossc_pkg::ossc_in_t              obs_item,
	output logic                            res_valid,
	input  logic                            res_ready,
	output ossc_pkg::ossc_out_t             res_item,
	input  logic                            cfg_we,
	input  logic [ossc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ossc_pkg::CFG_W-1:0]      cfg_data
);
	import ossc_pkg::*;

	localparam int STEP_W = $clog2(ATAN_ITERATIONS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ATAN_ITERATIONS - 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_CORDIC = 2'd1;
	localparam logic [1:0] ST_CHECK  = 2'd2;
	localparam logic [1:0] ST_FRAME  = 2'd3;

	logic [1:0]          state_q;
	logic [STEP_W-1:0]   step_q;
	logic                end_q;
	logic [ANGLE_W-1:0]  heading_q;
	logic [TIME_W-1:0]   time_q;
	logic [DELTA_W-1:0]  dx_abs_q, dy_abs_q;
	logic [SQ_W-1:0]     prod_q, d2_q, stop_sq_q, slow_sq_q;

	logic [RANGE_W-1:0]  stop_range_q, slow_range_q;
	logic [ANGLE_W-1:0]  stop_half_q, slow_half_q;
	logic [TIME_W-1:0]   hold_q;

	logic                frame_stop_q, frame_slow_q, latch_q;
	logic [TIME_W-1:0]   stamp_q;
	logic                res_valid_q;
	ossc_out_t           res_q;

	logic signed [DELTA_W-1:0] dx, dy;
	logic                obs_take, res_free, latch_next;
	logic [DELTA_W-1:0]  mul_a;
	logic [ANGLE_W-1:0]  bearing, diff, mag;
	logic                stop_hit, slow_hit;
	logic [TIME_W-1:0]   elapsed;
	ossc_cordic_ctl_t    cordic_ctl;

	assign obs_ready = (state_q == ST_IDLE);
	assign obs_take  = obs_valid && obs_ready;
	assign res_free  = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	assign dx = {obs_item.obs_x[POS_W-1], obs_item.obs_x}
	          - {obs_item.car_x[POS_W-1], obs_item.car_x};
	assign dy = {obs_item.obs_y[POS_W-1], obs_item.obs_y}
	          - {obs_item.car_y[POS_W-1], obs_item.car_y};

	assign cordic_ctl.load  = obs_take;
	assign cordic_ctl.step  = (state_q == ST_CORDIC);
	assign cordic_ctl.shift = SHIFT_W'(step_q);

	ossc_cordic u_cordic (
		.clk     (clk),
		.ctl     (cordic_ctl),
		.dx      (dx),
		.dy      (dy),
		.bearing (bearing)
	);

	// shared squarer operand
	always_comb begin
		priority if (step_q == STEP_W'(0)) begin
			mul_a = dx_abs_q;
		end else if (step_q == STEP_W'(1)) begin
			mul_a = dy_abs_q;
		end else if (step_q == STEP_W'(2)) begin
			mul_a = DELTA_W'(stop_range_q);
		end else begin
			mul_a = DELTA_W'(slow_range_q);
		end
	end

	assign diff     = bearing - heading_q;
	assign mag      = diff[ANGLE_W-1] ? (~diff + ANGLE_W'(1)) : diff;
	assign stop_hit = (d2_q < stop_sq_q) && (mag < stop_half_q);
	assign slow_hit = (d2_q < slow_sq_q) && (mag < slow_half_q);

	assign elapsed  = time_q - stamp_q;
	always_comb begin
		priority if (frame_stop_q) begin
			latch_next = 1'b1;
		end else if (latch_q && (elapsed >= hold_q)) begin
			latch_next = 1'b0;
		end else begin
			latch_next = latch_q;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_range_q <= STOP_RANGE_RST;
			stop_half_q  <= STOP_HALF_ANGLE_RST;
			slow_range_q <= SLOW_RANGE_RST;
			slow_half_q  <= SLOW_HALF_ANGLE_RST;
			hold_q       <= STOP_HOLD_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STOP_RANGE: begin
					stop_range_q <= cfg_data[RANGE_W-1:0];
				end
				CFG_STOP_HALF_ANGLE: begin
					stop_half_q <= cfg_data[ANGLE_W-1:0];
				end
				CFG_SLOW_RANGE: begin
					slow_range_q <= cfg_data[RANGE_W-1:0];
				end
				CFG_SLOW_HALF_ANGLE: begin
					slow_half_q <= cfg_data[ANGLE_W-1:0];
				end
				CFG_STOP_HOLD_MS: begin
					hold_q <= cfg_data[TIME_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// transaction payload and arithmetic
	always_ff @(posedge clk) begin
		if (obs_take) begin
			heading_q <= obs_item.car_heading;
			time_q    <= obs_item.frame_time_ms;
			dx_abs_q  <= dx[DELTA_W-1] ? DELTA_W'(-dx) : DELTA_W'(dx);
			dy_abs_q  <= dy[DELTA_W-1] ? DELTA_W'(-dy) : DELTA_W'(dy);
		end
		if (state_q == ST_CORDIC) begin
			prod_q <= SQ_W'(mul_a) * SQ_W'(mul_a);
			if (step_q == STEP_W'(1)) begin
				d2_q <= prod_q;
			end else if (step_q == STEP_W'(2)) begin
				d2_q <= d2_q + prod_q;
			end else if (step_q == STEP_W'(3)) begin
				stop_sq_q <= prod_q;
			end else if (step_q == STEP_W'(4)) begin
				slow_sq_q <= prod_q;
			end
		end
	end

	// sequencer and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			end_q        <= 1'b0;
			frame_stop_q <= 1'b0;
			frame_slow_q <= 1'b0;
			latch_q      <= 1'b0;
			stamp_q      <= '0;
			res_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			if (res_valid_q && res_ready && (state_q != ST_FRAME)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (obs_take) begin
						end_q <= obs_item.action || obs_item.frame_last;
						if (!obs_item.action && !frame_stop_q) begin
							state_q <= ST_CORDIC;
						end else if (obs_item.action || obs_item.frame_last) begin
							state_q <= ST_FRAME;
						end
					end
				end
				ST_CORDIC: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_LAST) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (stop_hit) begin
						frame_stop_q <= 1'b1;
					end else if (slow_hit) begin
						frame_slow_q <= 1'b1;
					end
					state_q <= end_q ? ST_FRAME : ST_IDLE;
				end
				ST_FRAME: begin
					if (res_free) begin
						latch_q <= latch_next;
						if (frame_stop_q) begin
							stamp_q <= time_q;
						end
						res_q.stop_active <= latch_next;
						res_q.slow_seen   <= frame_slow_q;
						res_valid_q       <= 1'b1;
						frame_stop_q      <= 1'b0;
						frame_slow_q      <= 1'b0;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for obstacle_sector_stop_slow_check. Obstacle frames go in
// over a valid/ready channel, and each frame status is compared with an in-bench
// sector and latch predictor. A directed set runs first, then random frames
// under several register settings and with idle and stall patterns on both
// channels.
// ----------------------------------------------------------------------------
module tb;
	import ossc_pkg::*;

	localparam int  CLK_HALF      = 5;
	localparam int  RESET_CYCLES  = 12;
	localparam int  CYCLE_LIMIT   = 400000;
	localparam int  SETTLE_CYCLES = 2 * ATAN_ITERATIONS_DEF + 8;
	localparam int  PHASE_ITEMS   = 70;
	localparam int  REPORT_MAX    = 10;
	localparam real TWO_PI        = 6.283185307179586;

	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd6;
	localparam logic [TIME_W-1:0]    T_WRAP       = 32'hFFFF_F800;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 obs_valid = 1'b0;
	logic                 obs_ready;
	ossc_in_t             obs_item  = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	ossc_out_t            res_item;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// register copy
	logic [RANGE_W-1:0] cur_stop_range = STOP_RANGE_RST;
	logic [ANGLE_W-1:0] cur_stop_half  = STOP_HALF_ANGLE_RST;
	logic [RANGE_W-1:0] cur_slow_range = SLOW_RANGE_RST;
	logic [ANGLE_W-1:0] cur_slow_half  = SLOW_HALF_ANGLE_RST;
	logic [TIME_W-1:0]  cur_hold_ms    = STOP_HOLD_MS_RST;

	// frame and latch state
	logic              latch_on    = 1'b0;
	logic [TIME_W-1:0] latch_stamp = '0;
	logic              frame_stop  = 1'b0;
	logic              frame_slow  = 1'b0;

	ossc_in_t          point_q[$];
	ossc_out_t         status_q[$];
	ossc_out_t         want_status;
	int                send_idle_pct = 20;
	int                recv_idle_pct = 53;
	int                mismatches    = 0;
	int                cycles        = 0;
	logic [TIME_W-1:0] now_ms        = 32'd100000;

	obstacle_sector_stop_slow_check i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.obs_valid (obs_valid),
		.obs_ready (obs_ready),
		.obs_item  (obs_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic void enqueue_item(input ossc_in_t it);
		point_q.insert(point_q.size(), it);
	endfunction

	function automatic logic [ANGLE_W-1:0] bearing_of(input longint dx, input longint dy);
		longint         x, y, t, xs, ys;
		logic [Z_W-1:0] z;
		if (dx == 0 && dy == 0)
			return '0;
		x = dx * (longint'(1) << GUARD_W);
		y = dy * (longint'(1) << GUARD_W);
		z = '0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = Z_QUARTER;
			end else begin
				t = x; x = -y; y = t; z = Z_THREE_QUARTER;
			end
		end
		for (int i = 0; i < ATAN_ITERATIONS_DEF && i < TAB_LEN; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
			end else begin
				x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
			end
		end
		z = z + Z_ROUND;
		return z[Z_W-1 -: ANGLE_W];
	endfunction

	function automatic void update_frame_status(input ossc_in_t it);
		longint             dx, dy, d2;
		logic [ANGLE_W-1:0] diff, mag;
		logic [TIME_W-1:0]  elapsed;
		logic               in_stop, in_slow;
		ossc_out_t          st;
		if (!it.action && !frame_stop) begin
			dx = longint'($signed(it.obs_x)) - longint'($signed(it.car_x));
			dy = longint'($signed(it.obs_y)) - longint'($signed(it.car_y));
			d2 = dx * dx + dy * dy;
			diff = bearing_of(dx, dy) - it.car_heading;
			mag = diff[ANGLE_W-1] ? -diff : diff;
			in_stop = d2 < longint'(cur_stop_range) * longint'(cur_stop_range)
				&& mag < cur_stop_half;
			in_slow = d2 < longint'(cur_slow_range) * longint'(cur_slow_range)
				&& mag < cur_slow_half;
			if (in_stop)
				frame_stop = 1'b1;
			else if (in_slow)
				frame_slow = 1'b1;
		end
		if (it.action || it.frame_last) begin
			elapsed = it.frame_time_ms - latch_stamp;
			if (frame_stop) begin
				latch_on = 1'b1;
				latch_stamp = it.frame_time_ms;
			end else if (latch_on && elapsed >= cur_hold_ms) begin
				latch_on = 1'b0;
			end
			st.stop_active = latch_on;
			st.slow_seen = frame_slow;
			status_q.insert(status_q.size(), st);
			frame_stop = 1'b0;
			frame_slow = 1'b0;
		end
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (obs_valid && obs_ready)
				update_frame_status(obs_item);
			if (!obs_valid || obs_ready) begin
				if (point_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					obs_item <= point_q.pop_front();
					obs_valid <= 1'b1;
				end else begin
					obs_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (status_q.size() == 0) begin
				if (mismatches < REPORT_MAX)
					$display("%0t: unexpected result transaction stop_active=%0b slow_seen=%0b",
						$time, res_item.stop_active, res_item.slow_seen);
				mismatches++;
			end else begin
				want_status = status_q.pop_front();
				if (res_item.stop_active !== want_status.stop_active
						|| res_item.slow_seen !== want_status.slow_seen) begin
					if (mismatches < REPORT_MAX)
						$display("%0t: expected stop_active=%0b slow_seen=%0b, got %0b %0b",
							$time, want_status.stop_active, want_status.slow_seen,
							res_item.stop_active, res_item.slow_seen);
					mismatches++;
				end
			end
		end
		res_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_STOP_RANGE:      cur_stop_range = val[RANGE_W-1:0];
			CFG_STOP_HALF_ANGLE: cur_stop_half = val[ANGLE_W-1:0];
			CFG_SLOW_RANGE:      cur_slow_range = val[RANGE_W-1:0];
			CFG_SLOW_HALF_ANGLE: cur_slow_half = val[ANGLE_W-1:0];
			CFG_STOP_HOLD_MS:    cur_hold_ms = val[TIME_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic program_regs(input logic [CFG_W-1:0] stop_r, input logic [CFG_W-1:0] stop_h,
			input logic [CFG_W-1:0] slow_r, input logic [CFG_W-1:0] slow_h,
			input logic [CFG_W-1:0] hold);
		write_reg(CFG_STOP_RANGE, stop_r);
		write_reg(CFG_STOP_HALF_ANGLE, stop_h);
		write_reg(CFG_SLOW_RANGE, slow_r);
		write_reg(CFG_SLOW_HALF_ANGLE, slow_h);
		write_reg(CFG_STOP_HOLD_MS, hold);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (point_q.size() != 0 || obs_valid || status_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic ossc_in_t noise_item();
		logic [159:0] blob;
		blob = {$urandom, $urandom, $urandom, $urandom, $urandom};
		return blob[$bits(ossc_in_t)-1:0];
	endfunction

	function automatic ossc_in_t pt(input logic signed [POS_W-1:0] ox,
			input logic signed [POS_W-1:0] oy, input logic signed [POS_W-1:0] cx,
			input logic signed [POS_W-1:0] cy, input logic [ANGLE_W-1:0] hd,
			input logic [TIME_W-1:0] t, input logic last);
		ossc_in_t it;
		it.action = 1'b0;
		it.obs_x = ox;
		it.obs_y = oy;
		it.car_x = cx;
		it.car_y = cy;
		it.car_heading = hd;
		it.frame_time_ms = t;
		it.frame_last = last;
		return it;
	endfunction

	function automatic ossc_in_t end_at(input logic [TIME_W-1:0] t, input logic last);
		ossc_in_t it;
		it = noise_item();
		it.action = 1'b1;
		it.frame_time_ms = t;
		it.frame_last = last;
		return it;
	endfunction

	// offset that lands near the heading, inside or just outside a sector
	function automatic void aim_offset(input logic [ANGLE_W-1:0] hd, output longint ox,
			output longint oy);
		int unsigned reach, half;
		real         r, a;
		reach = $urandom_range(1) ? 32'(cur_stop_range) : 32'(cur_slow_range);
		half = $urandom_range(1) ? 32'(cur_stop_half) : 32'(cur_slow_half);
		r = real'($urandom_range(0, reach + reach / 4 + 16));
		a = TWO_PI * (real'(hd) + real'($urandom_range(0, 2 * half + 16)) - real'(half) - 8.0)
			/ 65536.0;
		ox = longint'($rtoi(r * $cos(a)));
		oy = longint'($rtoi(r * $sin(a)));
	endfunction

	function automatic int queue_frame();
		ossc_in_t                it;
		logic signed [POS_W-1:0] cx, cy;
		logic [ANGLE_W-1:0]      hd;
		longint                  ox, oy;
		int                      npts;
		logic                    end_on_last;
		npts = $urandom_range(0, 5);
		end_on_last = $urandom_range(1) && npts != 0;
		hd = ANGLE_W'($urandom);
		if ($urandom_range(3) == 0) begin
			cx = POS_W'($urandom);
			cy = POS_W'($urandom);
		end else begin
			cx = POS_W'($urandom_range(0, 8191) - 4096);
			cy = POS_W'($urandom_range(0, 8191) - 4096);
		end
		for (int k = 0; k < npts; k++) begin
			it = noise_item();
			if ($urandom_range(4) != 0) begin
				aim_offset(hd, ox, oy);
				it.obs_x = POS_W'(longint'(cx) + ox);
				it.obs_y = POS_W'(longint'(cy) + oy);
			end
			it.action = 1'b0;
			it.car_x = cx;
			it.car_y = cy;
			it.car_heading = hd;
			it.frame_time_ms = now_ms;
			it.frame_last = end_on_last && k == npts - 1;
			enqueue_item(it);
		end
		if (!end_on_last) begin
			it = end_at(now_ms, 1'($urandom_range(1)));
			it.car_x = cx;
			it.car_y = cy;
			it.car_heading = hd;
			enqueue_item(it);
		end
		case ($urandom_range(15))
			0:       now_ms = now_ms + $urandom;
			1:       now_ms = now_ms + cur_hold_ms;
			2:       now_ms = now_ms + cur_hold_ms - 1;
			default: now_ms = now_ms + $urandom_range(0, 3000);
		endcase
		return npts + (end_on_last ? 0 : 1);
	endfunction

	task automatic queue_random(input int target);
		int added;
		added = 0;
		@(negedge clk);
		while (added < target) begin
			if ($urandom_range(9) == 0) begin
				enqueue_item(noise_item());
				added++;
			end else begin
				added += queue_frame();
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed frames at reset settings
		enqueue_item(pt(100, 200, 100, 200, 16'h1234, 1000, 1'b1));  // zero offset
		enqueue_item(end_at(5999, 1'b0));
		enqueue_item(end_at(6000, 1'b1));
		enqueue_item(pt(-1280, 0, 0, 0, 16'h0000, 7000, 1'b0));       // straight behind
		enqueue_item(pt(7680, 0, 0, 0, 16'h0000, 7000, 1'b0));
		enqueue_item(pt(1280, 0, 0, 0, 16'h0000, 7000, 1'b0));
		enqueue_item(pt(2560, 0, 0, 0, 16'h0000, 7000, 1'b1));        // after a stop
		enqueue_item(pt(2560, 0, 0, 0, 16'h0000, 8000, 1'b1));
		enqueue_item(pt(24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF,
			16'hFFFF, 20000, 1'b0));
		enqueue_item(pt(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000,
			16'h0000, 20000, 1'b1));
		enqueue_item(pt(0, 1280, 0, 0, 16'h4000, T_WRAP, 1'b1));       // stamp near wrap
		enqueue_item(end_at(32'h0000_0300, 1'b1));
		enqueue_item(end_at(32'h0000_0B88, 1'b0));
		enqueue_item(pt(3840, 0, 0, 0, 16'h0000, 40000, 1'b1));        // on the range edge
		enqueue_item(pt(7680, 0, 0, 0, 16'h0000, 41000, 1'b0));
		enqueue_item(end_at(41000, 1'b1));
		wait_idle();

		program_regs(32'hAB80_0F00, 32'h1234_00B6, 32'h0000_2800, 32'h0000_0E39, 32'd5000);
		queue_random(PHASE_ITEMS);
		wait_idle();

		program_regs(32'hFF80_0000, 32'h0000_0000, 32'h007F_FFFF, 32'hFFFF_8000, 32'd0);
		queue_random(PHASE_ITEMS);
		wait_idle();

		send_idle_pct <= 53;
		recv_idle_pct <= 20;
		program_regs(32'h007F_FFFF, 32'h0000_8000, 32'h0000_0000, 32'h0000_0000,
			32'hFFFF_FFFF);
		queue_random(PHASE_ITEMS);
		wait_idle();

		program_regs($urandom_range(256, 6000), $urandom_range(32769, 65535),
			$urandom_range(2000, 20000), $urandom_range(0, 8000), $urandom_range(0, 8000));
		write_reg(CFG_UNMAPPED, $urandom);
		queue_random(PHASE_ITEMS);
		wait_idle();

		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		program_regs(32'd2560, 32'hFFFF_FFFF, 32'd2560, $urandom_range(0, 32768),
			$urandom_range(0, 3000));
		queue_random(PHASE_ITEMS);
		wait_idle();

		program_regs($urandom, $urandom_range(0, 32768), $urandom_range(1000, 30000),
			$urandom_range(0, 32768), $urandom_range(0, 10000));
		queue_random(PHASE_ITEMS);
		wait_idle();

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
